// ----- design/ps2_mouse_packet_tracker_core_defines.svh -----
// Assertion macros for the PS/2 mouse packet tracker.
// Used by ps2mpt_tracker; no other dependencies.
`ifndef PS2_MOUSE_PACKET_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition implies consequence in the same cycle
`define PS2MPT_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);
// Condition implies consequence in the next cycle
`define PS2MPT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);
`else
`define PS2MPT_ASSERT_NOW(label, clk, rst, cond, cons, msg)
`define PS2MPT_ASSERT_NEXT(label, clk, rst, cond, cons, msg)
`endif

`endif

// ----- design/ps2mpt_pkg.sv -----
// Shared types, constants and helper functions for the PS/2 mouse packet tracker.
// No dependencies.
`timescale 1ns / 1ps

package ps2mpt_pkg;

  // Coordinate and screen size widths
  localparam int CoordBits  = 12;
  localparam int SizeBits   = 13;
  localparam int SumBits    = CoordBits + 2;
  localparam int ResultBits = 2 * CoordBits + 7;
  localparam int TdataBits  = ((ResultBits + 7) / 8) * 8;
  localparam int CfgIdxBits = 2;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [SizeBits-1:0]  size_t;
  typedef logic [TdataBits-1:0] tdata_t;
  typedef logic [ResultBits-1:0] result_t;

  localparam size_t  WidthReset  = size_t'(640);
  localparam size_t  HeightReset = size_t'(480);
  localparam coord_t StartPos    = coord_t'(20);

  // Register indexes
  localparam logic [CfgIdxBits-1:0] RegScreenWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegScreenHeight = 2'd1;

  // Position of a byte within a packet
  typedef enum logic [1:0] {
    PhaseButtons = 2'd0,
    PhaseDx      = 2'd1,
    PhaseDy      = 2'd2
  } phase_t;

  // Registered input beat
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_beat_t;

  // Per-axis clamp limits
  typedef struct packed {
    coord_t x_lim;
    coord_t y_lim;
  } limits_t;

  // Screen size to largest coordinate: zero acts as one, capped to coordinate range
  function automatic coord_t size_to_limit(size_t size);
    logic [SizeBits-1:0]          lim;
    logic [SizeBits+CoordBits-1:0] wide;
    logic [SizeBits+CoordBits-1:0] cap;
    lim  = (size == '0) ? '0 : size - size_t'(1);
    wide = (SizeBits+CoordBits)'(lim);
    cap  = (SizeBits+CoordBits)'({CoordBits{1'b1}});
    if (wide > cap) begin
      wide = cap;
    end
    return wide[CoordBits-1:0];
  endfunction

  // Clamp a signed sum to [0, lim]
  function automatic coord_t clamp_axis(logic signed [SumBits-1:0] v, coord_t lim);
    logic signed [SumBits-1:0] lim_s;
    lim_s = signed'({2'b00, lim});
    if (v < 0) begin
      return '0;
    end else if (v > lim_s) begin
      return lim;
    end
    return v[CoordBits-1:0];
  endfunction

endpackage

// ----- design/ps2mpt_cfg.sv -----
// Screen size registers and the derived clamp limits.
// Depends on ps2mpt_pkg.
`timescale 1ns / 1ps

module ps2mpt_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ps2mpt_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [ps2mpt_pkg::SizeBits-1:0]   cfg_data,
  output ps2mpt_pkg::limits_t               limits
);

  ps2mpt_pkg::size_t screen_width;
  ps2mpt_pkg::size_t screen_height;

  assign cfg_ready = 1'b1;

  // Register writes; other indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ps2mpt_pkg::WidthReset;
      screen_height <= ps2mpt_pkg::HeightReset;
    end else if (cfg_valid) begin
      if (cfg_index == ps2mpt_pkg::RegScreenWidth) begin
        screen_width <= cfg_data;
      end
      if (cfg_index == ps2mpt_pkg::RegScreenHeight) begin
        screen_height <= cfg_data;
      end
    end
  end

  // Limits follow the registers directly
  always_comb begin
    limits.x_lim = ps2mpt_pkg::size_to_limit(screen_width);
    limits.y_lim = ps2mpt_pkg::size_to_limit(screen_height);
  end

endmodule

// ----- design/ps2mpt_in_reg.sv -----
// Input register stage for incoming mouse bytes.
// Depends on ps2mpt_pkg.
`timescale 1ns / 1ps

module ps2mpt_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] data_byte
  input  logic                take,
  output ps2mpt_pkg::in_beat_t beat
);

  logic       valid;
  logic [7:0] data;

  // Room when empty or when the held beat moves on this cycle
  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data <= s_tdata;
    end
  end

  assign beat.valid = valid;
  assign beat.data  = data;

endmodule

// ----- design/ps2mpt_tracker.sv -----
// Packet byte counter, cursor update and result register.
// Depends on ps2mpt_pkg and ps2_mouse_packet_tracker_core_defines.svh.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_core_defines.svh"

module ps2mpt_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  ps2mpt_pkg::in_beat_t beat,
  input  ps2mpt_pkg::limits_t  limits,
  output logic                 take,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output ps2mpt_pkg::tdata_t   m_tdata
);

  ps2mpt_pkg::phase_t phase, phase_next;
  logic [2:0]         held_buttons;
  logic [7:0]         delta_x_byte;
  ps2mpt_pkg::coord_t position_x;
  ps2mpt_pkg::coord_t position_y;
  logic [2:0]         previous_buttons;

  logic               pkt_end;
  ps2mpt_pkg::coord_t new_x, new_y;
  logic [3:0]         edges;
  ps2mpt_pkg::result_t result_word;

  logic signed [ps2mpt_pkg::SumBits-1:0] sum_x, sum_y;

  // Unused phase code counts as packet end
  assign pkt_end = (phase != ps2mpt_pkg::PhaseButtons) && (phase != ps2mpt_pkg::PhaseDx);

  // Only a packet-end beat needs the result register
  assign take = beat.valid && (!m_tvalid || m_tready || !pkt_end);

  // Next phase
  always_comb begin
    case (phase)
      ps2mpt_pkg::PhaseButtons: phase_next = ps2mpt_pkg::PhaseDx;
      ps2mpt_pkg::PhaseDx:      phase_next = ps2mpt_pkg::PhaseDy;
      default:                  phase_next = ps2mpt_pkg::PhaseButtons;
    endcase
  end

  // Cursor move and button edges
  always_comb begin
    sum_x = signed'({2'b00, position_x}) +
            ps2mpt_pkg::SumBits'(signed'(delta_x_byte));
    sum_y = signed'({2'b00, position_y}) -
            ps2mpt_pkg::SumBits'(signed'(beat.data));
    new_x = ps2mpt_pkg::clamp_axis(sum_x, limits.x_lim);
    new_y = ps2mpt_pkg::clamp_axis(sum_y, limits.y_lim);
    // right_released, right_pressed, left_released, left_pressed
    edges = {previous_buttons[1] & ~held_buttons[1],
             ~previous_buttons[1] & held_buttons[1],
             previous_buttons[0] & ~held_buttons[0],
             ~previous_buttons[0] & held_buttons[0]};
    result_word = {edges, held_buttons, new_y, new_x};
  end

  // Packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= ps2mpt_pkg::PhaseButtons;
      held_buttons     <= 3'd0;
      delta_x_byte     <= 8'd0;
      position_x       <= ps2mpt_pkg::StartPos;
      position_y       <= ps2mpt_pkg::StartPos;
      previous_buttons <= 3'd0;
    end else if (take) begin
      phase <= phase_next;
      case (phase)
        ps2mpt_pkg::PhaseButtons: held_buttons <= beat.data[2:0];
        ps2mpt_pkg::PhaseDx:      delta_x_byte <= beat.data;
        default: begin
          position_x       <= new_x;
          position_y       <= new_y;
          previous_buttons <= held_buttons;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && pkt_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pkt_end) begin
      m_tdata <= ps2mpt_pkg::tdata_t'(result_word);
    end
  end

  localparam int EdgeLo = 2 * ps2mpt_pkg::CoordBits + 3;

  `PS2MPT_ASSERT_NOW(a_left_edges_excl, clk, rst, m_tvalid, !(m_tdata[EdgeLo] && m_tdata[EdgeLo+1]), "left press and release together")
  `PS2MPT_ASSERT_NOW(a_right_edges_excl, clk, rst, m_tvalid, !(m_tdata[EdgeLo+2] && m_tdata[EdgeLo+3]), "right press and release together")
  `PS2MPT_ASSERT_NEXT(a_first_byte_advances, clk, rst, take && (phase == ps2mpt_pkg::PhaseButtons), phase == ps2mpt_pkg::PhaseDx, "first byte did not advance phase")
  `PS2MPT_ASSERT_NEXT(a_packet_end_result, clk, rst, take && pkt_end, m_tvalid && (phase == ps2mpt_pkg::PhaseButtons), "packet end without result")

endmodule

// ----- design/ps2_mouse_packet_tracker_core.sv -----
// Top level of the PS/2 mouse packet tracker.
// Depends on ps2mpt_pkg, ps2mpt_cfg, ps2mpt_in_reg and ps2mpt_tracker.
`timescale 1ns / 1ps

// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) takes raw mouse bytes, one per beat.
//   Every three bytes form a packet: buttons, dx, dy, with no sync check.
//   Master stream (m_tvalid/m_tready/m_tdata) gives one beat per packet with the
//   clamped cursor position, the held buttons and left/right press and release
//   edges against the previous packet.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes screen_width
//   (index 0) and screen_height (index 1); other indexes are ignored. Writes take
//   effect at the next completed packet; cfg_ready is always high.
// Throughput: one byte per cycle unless a third byte waits on the result register.
//   A byte first enters the input register; the packet logic then updates state
//   and, on the third byte, loads the result register with the result.
// Stall: the input register keeps taking first and second bytes while a result
//   waits; a third byte waits in the input register until the result register
//   frees, and s_tready drops behind it.
// Reset (rst, synchronous): byte count to the first byte, cursor to (20, 20),
//   buttons cleared, screen 640 by 480, no result pending.

module ps2_mouse_packet_tracker_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [11:0] cursor_x, [23:12] cursor_y, [26:24] button_state, [27] left_pressed,
  // [28] left_released, [29] right_pressed, [30] right_released, [31] zero
  output logic [ps2mpt_pkg::TdataBits-1:0]  m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ps2mpt_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [ps2mpt_pkg::SizeBits-1:0]   cfg_data
);

  ps2mpt_pkg::limits_t  limits;
  ps2mpt_pkg::in_beat_t beat;
  logic                 take;

  // Screen size registers
  ps2mpt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  // Input register
  ps2mpt_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .beat     (beat)
  );

  // Packet tracking and result register
  ps2mpt_tracker u_tracker (
    .clk      (clk),
    .rst      (rst),
    .beat     (beat),
    .limits   (limits),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
